/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Short forms for the concurrent assertions used in the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Checks that a consequent holds whenever an antecedent holds.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* rtl/ksta_pkg.sv */
// ----------------------------------------------------------------------------
// ksta_pkg
// Types and constants of the keyed slot table allocator.
// ----------------------------------------------------------------------------
package ksta_pkg;

  localparam int SLOTS_DEF = 64;
  localparam int OP_W      = 2;
  localparam int KEY_W     = 16;
  localparam int IDX_W     = 6;
  localparam int STATUS_W  = 3;

  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP  = 2'd0,
    OP_CREATE  = 2'd1,
    OP_RELEASE = 2'd2,
    OP_CLEAR   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND    = 3'd0,
    ST_CREATED  = 3'd1,
    ST_MISS     = 3'd2,
    ST_FULL     = 3'd3,
    ST_RELEASED = 3'd4,
    ST_IGNORED  = 3'd5,
    ST_CLEARED  = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_NOHIT,
    S_POP,
    S_REL_CHK
  } state_t;

endpackage

/* rtl/keyed_slot_table_allocator.sv */
// ----------------------------------------------------------------------------
// keyed_slot_table_allocator
// Table of keyed slots with lookup, lookup-or-create, release and release-all.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Its result appears
// on status and slot_found, flagged by done for exactly one cycle, in the
// cycle in which busy falls (in the cycle after the transfer for commands that
// never raise busy); the receiver cannot stall it. Lookups walk the key
// memory through its single read port, one slot per cycle, over the N slots
// handed out since the last release-all: a hit ends the scan at once, a miss
// goes on to a no-hit step, and a create from the free stack adds a pop step
// after that. A release of one of those N slots keeps busy high for a single
// check step, whether or not the slot is still in use; a release-all and a
// release of any other slot do not raise busy at all. The table needs no
// clearing pass after reset or release-all.
module keyed_slot_table_allocator #(
  parameter int SLOTS = ksta_pkg::SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [ksta_pkg::OP_W-1:0]     operation,
  input  logic [ksta_pkg::KEY_W-1:0]    loco_id,
  input  logic [ksta_pkg::IDX_W-1:0]    slot_index,
  output logic                          done,
  output logic [ksta_pkg::STATUS_W-1:0] status,
  output logic [ksta_pkg::IDX_W-1:0]    slot_found
);
  import ksta_pkg::*;

  `include "assert_macros.svh"

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  // Key memory entry: in-use flag above the key.
  logic [KEY_W:0]  kmem [SLOTS];
  logic [IW-1:0]   stk  [SLOTS];

  state_t          state, state_next;
  op_t             op_q, op_next;
  logic [KEY_W-1:0] key_q, key_next;
  logic [IDX_W-1:0] idx_q, idx_next;
  logic [IW-1:0]   cmp_idx, cmp_idx_next;
  logic [CW-1:0]   free_depth, free_depth_next;
  logic [CW-1:0]   ever_used, ever_used_next;
  logic            done_next;
  status_t         status_q, status_next;
  logic [IW-1:0]   slot_q, slot_next;

  logic            kmem_we;
  logic [IW-1:0]   kmem_waddr, kmem_raddr;
  logic [KEY_W:0]  kmem_wdata, kmem_rdata;
  logic            stk_we;
  logic [IW-1:0]   stk_waddr, stk_raddr, stk_wdata, stk_rdata;
  logic            hit;
  logic            idx_ok;

  always_ff @(posedge clk) begin
    if (kmem_we) begin
      kmem[kmem_waddr] <= kmem_wdata;
    end
    kmem_rdata <= kmem[kmem_raddr];
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk[stk_waddr] <= stk_wdata;
    end
    stk_rdata <= stk[stk_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      free_depth <= '0;
      ever_used  <= '0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      free_depth <= free_depth_next;
      ever_used  <= ever_used_next;
      done       <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    op_q     <= op_next;
    key_q    <= key_next;
    idx_q    <= idx_next;
    cmp_idx  <= cmp_idx_next;
    status_q <= status_next;
    slot_q   <= slot_next;
  end

  // The top of the free stack is always being read, so it is ready by the
  // time S_POP uses it.
  assign stk_raddr = IW'(free_depth - CW'(1));
  assign hit       = kmem_rdata[KEY_W] && (kmem_rdata[KEY_W-1:0] == key_q);
  // Only slots below the fill count have been written since the last release-all.
  assign idx_ok    = (32'(slot_index) < SLOTS) && (32'(slot_index) < 32'(ever_used));

  always_comb begin
    state_next      = state;
    op_next         = op_q;
    key_next        = key_q;
    idx_next        = idx_q;
    cmp_idx_next    = cmp_idx;
    free_depth_next = free_depth;
    ever_used_next  = ever_used;
    done_next       = 1'b0;
    status_next     = status_q;
    slot_next       = slot_q;
    kmem_we         = 1'b0;
    kmem_waddr      = '0;
    kmem_wdata      = '0;
    kmem_raddr      = '0;
    stk_we          = 1'b0;
    stk_waddr       = IW'(free_depth);
    stk_wdata       = IW'(idx_q);

    case (state)
      S_IDLE: begin
        if (start) begin
          op_next  = op_t'(operation);
          key_next = loco_id;
          idx_next = slot_index;
          case (op_t'(operation))
            OP_CLEAR: begin
              free_depth_next = '0;
              ever_used_next  = '0;
              done_next       = 1'b1;
              status_next     = ST_CLEARED;
              slot_next       = '0;
            end
            OP_RELEASE: begin
              if (idx_ok) begin
                kmem_raddr = IW'(slot_index);
                state_next = S_REL_CHK;
              end else begin
                done_next   = 1'b1;
                status_next = ST_IGNORED;
                slot_next   = '0;
              end
            end
            default: begin
              cmp_idx_next = '0;
              kmem_raddr   = '0;
              if (ever_used == '0) begin
                state_next = S_NOHIT;
              end else begin
                state_next = S_SCAN;
              end
            end
          endcase
        end
      end

      S_SCAN: begin
        // Compare the slot read last cycle while reading the next one.
        kmem_raddr = cmp_idx + IW'(1);
        if (hit) begin
          done_next   = 1'b1;
          status_next = ST_FOUND;
          slot_next   = cmp_idx;
          state_next  = S_IDLE;
        end else if (CW'(cmp_idx) + CW'(1) == ever_used) begin
          state_next = S_NOHIT;
        end else begin
          cmp_idx_next = cmp_idx + IW'(1);
        end
      end

      S_NOHIT: begin
        if (op_q == OP_LOOKUP) begin
          done_next   = 1'b1;
          status_next = ST_MISS;
          slot_next   = '0;
          state_next  = S_IDLE;
        end else if (free_depth != '0) begin
          state_next = S_POP;
        end else if (ever_used < CW'(SLOTS)) begin
          kmem_we        = 1'b1;
          kmem_waddr     = IW'(ever_used);
          kmem_wdata     = {1'b1, key_q};
          ever_used_next = ever_used + CW'(1);
          done_next      = 1'b1;
          status_next    = ST_CREATED;
          slot_next      = IW'(ever_used);
          state_next     = S_IDLE;
        end else begin
          done_next   = 1'b1;
          status_next = ST_FULL;
          slot_next   = '0;
          state_next  = S_IDLE;
        end
      end

      S_POP: begin
        kmem_we         = 1'b1;
        kmem_waddr      = stk_rdata;
        kmem_wdata      = {1'b1, key_q};
        free_depth_next = free_depth - CW'(1);
        done_next       = 1'b1;
        status_next     = ST_CREATED;
        slot_next       = stk_rdata;
        state_next      = S_IDLE;
      end

      S_REL_CHK: begin
        if (kmem_rdata[KEY_W] && (free_depth < CW'(SLOTS))) begin
          kmem_we         = 1'b1;
          kmem_waddr      = IW'(idx_q);
          kmem_wdata      = {1'b0, kmem_rdata[KEY_W-1:0]};
          stk_we          = 1'b1;
          free_depth_next = free_depth + CW'(1);
          status_next     = ST_RELEASED;
        end else begin
          status_next = ST_IGNORED;
        end
        done_next  = 1'b1;
        slot_next  = '0;
        state_next = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy       = (state != S_IDLE);
  assign status     = status_q;
  assign slot_found = IDX_W'(slot_q);

  `ASSERT_ALWAYS(a_fill_bound, clk, rst, ever_used <= CW'(SLOTS), "fill count beyond table size")
  `ASSERT_ALWAYS(a_free_bound, clk, rst, free_depth <= ever_used,
                 "free stack deeper than fill count")
  `ASSERT_IMPLY(a_scan_range, clk, rst, state == S_SCAN, CW'(cmp_idx) < ever_used,
                "scan past the filled slots")
  `ASSERT_IMPLY(a_pop_nonempty, clk, rst, state == S_POP, free_depth != '0,
                "pop from an empty free stack")
  `ASSERT_IMPLY(a_busy_done, clk, rst, busy && !$past(busy) && !$past(rst), !done,
                "result raised while a command is still running")

endmodule
